@@ rtl/yaz_pkg.sv @@
// shared types and constants for the yaz0 stream decompressor
`default_nettype none
package yaz_pkg;

  // fixed format constants
  localparam int unsigned WindowSize = 4096;
  localparam int unsigned WinAw      = 12;
  localparam int unsigned LenW       = 25;
  localparam logic [4:0]  HeaderBytes  = 5'd16;
  localparam logic [8:0]  ShortLenBias = 9'd2;
  localparam logic [8:0]  LongLenBase  = 9'h12;
  localparam int unsigned CmdDepth   = 2;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_t;

  // output word
  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  out_count;
    logic        run_last;
    logic        stream_done;
    logic        bad_reference;
  } out_t;

  // command classes passed from parser to executor
  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_NOP,
    CMD_LIT,
    CMD_CPY
  } cmd_kind_e;

  typedef struct packed {
    logic       restart;
    cmd_kind_e  kind;
    logic [7:0] lit;
    logic [11:0] dist_m1;
    logic [8:0] len;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/yaz_front.sv @@
// parser: marks the header bytes and turns code, literal and reference bytes into commands
`default_nettype none
module yaz_front import yaz_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire in_t  in_data_i,
  input  wire logic q_full_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CODE   = 3'd1;
  localparam logic [2:0] PH_ITEM   = 3'd2;
  localparam logic [2:0] PH_REF2   = 3'd3;
  localparam logic [2:0] PH_REF3   = 3'd4;

  logic [2:0] ph_q, ph_d, ph_e;
  logic [4:0] hl_q, hl_d, hl_e;
  logic [7:0] gc_q, gc_d, gc_e;
  logic [3:0] gb_q, gb_d, gb_e;
  logic [7:0] r1_q, r1_d, r1_e;
  logic [7:0] r2_q, r2_d, r2_e;
  logic       ss;
  logic [7:0] b;
  logic [3:0] gb_dec;

  assign push_o = in_valid_i & ~q_full_i;
  assign ss     = in_data_i.stream_start;
  assign b      = in_data_i.in_byte;

  // restart applied before the byte is parsed
  assign ph_e = ss ? PH_HEADER   : ph_q;
  assign hl_e = ss ? HeaderBytes : hl_q;
  assign gc_e = ss ? 8'd0 : gc_q;
  assign gb_e = ss ? 4'd0 : gb_q;
  assign r1_e = ss ? 8'd0 : r1_q;
  assign r2_e = ss ? 8'd0 : r2_q;
  assign gb_dec = (gb_e != 4'd0) ? gb_e - 4'd1 : 4'd0;

  // byte classification
  always_comb begin
    ph_d = ph_e;
    hl_d = hl_e;
    gc_d = gc_e;
    gb_d = gb_e;
    r1_d = r1_e;
    r2_d = r2_e;
    cmd_o.restart = ss;
    cmd_o.kind    = CMD_NOP;
    cmd_o.lit     = b;
    cmd_o.dist_m1 = 12'd0;
    cmd_o.len     = 9'd0;
    unique case (ph_e)
      PH_HEADER: begin
        cmd_o.kind = CMD_HDR;
        hl_d = (hl_e != 5'd0) ? hl_e - 5'd1 : hl_e;
        if (hl_d == 5'd0) ph_d = PH_CODE;
      end
      PH_CODE: begin
        gc_d = b;
        gb_d = 4'd8;
        ph_d = PH_ITEM;
      end
      PH_ITEM: begin
        if (gc_e[7]) begin
          cmd_o.kind = CMD_LIT;
          gc_d = {gc_e[6:0], 1'b0};
          gb_d = gb_dec;
          ph_d = (gb_dec == 4'd0) ? PH_CODE : PH_ITEM;
        end else begin
          r1_d = b;
          ph_d = PH_REF2;
        end
      end
      PH_REF2: begin
        r2_d = b;
        if (r1_e[7:4] != 4'd0) begin
          cmd_o.kind    = CMD_CPY;
          cmd_o.dist_m1 = {r1_e[3:0], b};
          cmd_o.len     = {5'd0, r1_e[7:4]} + ShortLenBias;
          gc_d = {gc_e[6:0], 1'b0};
          gb_d = gb_dec;
          ph_d = (gb_dec == 4'd0) ? PH_CODE : PH_ITEM;
        end else begin
          ph_d = PH_REF3;
        end
      end
      PH_REF3: begin
        cmd_o.kind    = CMD_CPY;
        cmd_o.dist_m1 = {r1_e[3:0], r2_e};
        cmd_o.len     = {1'b0, b} + LongLenBase;
        gc_d = {gc_e[6:0], 1'b0};
        gb_d = gb_dec;
        ph_d = (gb_dec == 4'd0) ? PH_CODE : PH_ITEM;
      end
      default: ph_d = PH_CODE;
    endcase
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HEADER;
      hl_q <= HeaderBytes;
      gc_q <= 8'd0;
      gb_q <= 4'd0;
      r1_q <= 8'd0;
      r2_q <= 8'd0;
    end else if (push_o) begin
      ph_q <= ph_d;
      hl_q <= hl_d;
      gc_q <= gc_d;
      gb_q <= gb_d;
      r1_q <= r1_d;
      r2_q <= r2_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/yaz_cmd_fifo.sv @@
// short command queue between parser and executor
`default_nettype none
module yaz_cmd_fifo import yaz_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  localparam int unsigned PtrW = $clog2(CmdDepth);

  cmd_t              mem_q [CmdDepth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rp_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PtrW'(1);
      if (pop_i)  rp_q <= rp_q + PtrW'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (PtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(CmdDepth)) else $error("command queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty command queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full command queue");
`endif

endmodule
`default_nettype wire

@@ rtl/yaz_back.sv @@
// executor: history window, copy engine, byte packing and output register
`default_nettype none
module yaz_back import yaz_pkg::*; #(
  parameter int unsigned OutBytes = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [LenW-1:0] out_len_i,
  input  wire logic            q_valid_i,
  input  wire cmd_t            cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_t                 out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRD  = 2'd1;
  localparam logic [1:0] S_CEM  = 2'd2;

  logic [1:0]      st_q, st_d;
  logic [LenW-1:0] bw_q, bw_d, bw_cur, bw_n;
  logic            fin_q, fin_d, fin_cur;
  logic [12:0]     dist_q, dist_d;
  logic [8:0]      rem_q, rem_d, rem_after;
  logic [63:0]     pk_data_q, data_n;
  logic [3:0]      pk_cnt_q, cnt_n;
  logic            pk_bad_q;
  logic            out_vld_q;
  out_t            out_q;
  logic [7:0]      hist [WindowSize];
  logic [7:0]      rd_q;
  logic [WinAw-1:0] raddr;
  logic            src_bad;
  logic            live, emit_en, emit_bad, over, done, flush, out_free, ok, do_emit;
  logic [7:0]      emit_b;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_free    = ~out_vld_q | ~out_stall_i;

  // restart takes effect when its command is taken
  assign bw_cur  = (st_q == S_IDLE && q_valid_i && cmd_i.restart) ? '0 : bw_q;
  assign fin_cur = (st_q == S_IDLE && q_valid_i && cmd_i.restart) ? 1'b0 : fin_q;
  assign live    = (cmd_i.kind != CMD_HDR) && !(fin_cur || (bw_cur >= out_len_i));

  // copy source address and before-start check
  assign raddr   = WinAw'(bw_q - {{(LenW-13){1'b0}}, dist_q});
  assign src_bad = ({{(LenW-13){1'b0}}, dist_q} > bw_q);

  // shared byte emission and packing
  always_comb begin
    emit_en   = 1'b0;
    emit_b    = cmd_i.lit;
    emit_bad  = 1'b0;
    rem_after = 9'd0;
    if (st_q == S_IDLE) begin
      emit_en = q_valid_i && live && (cmd_i.kind == CMD_LIT);
    end else if (st_q == S_CEM) begin
      emit_en   = 1'b1;
      emit_bad  = src_bad;
      emit_b    = src_bad ? 8'd0 : rd_q;
      rem_after = rem_q - 9'd1;
    end
    bw_n  = bw_cur + LenW'(1);
    cnt_n = pk_cnt_q + 4'd1;
    data_n = pk_data_q;
    data_n[8*pk_cnt_q[2:0] +: 8] = emit_b;
    done  = (bw_n >= out_len_i);
    over  = (rem_after == 9'd0) || done;
    flush = (cnt_n == 4'(OutBytes)) || over;
    ok    = ~flush | out_free;
    do_emit = emit_en & ok;
  end

  // sequencer
  always_comb begin
    st_d   = st_q;
    bw_d   = bw_q;
    fin_d  = fin_q;
    dist_d = dist_q;
    rem_d  = rem_q;
    pop_o  = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (live && cmd_i.kind == CMD_LIT) begin
            pop_o = ok;
          end else begin
            pop_o = 1'b1;
          end
          if (pop_o) begin
            bw_d  = bw_cur;
            fin_d = fin_cur | ((cmd_i.kind != CMD_HDR) && (bw_cur >= out_len_i));
            if (live && cmd_i.kind == CMD_CPY) begin
              dist_d = {1'b0, cmd_i.dist_m1} + 13'd1;
              rem_d  = cmd_i.len;
              st_d   = S_CRD;
            end
          end
        end
      end
      S_CRD: st_d = S_CEM;
      S_CEM: begin
        if (ok) begin
          rem_d = rem_after;
          st_d  = over ? S_IDLE : S_CRD;
        end
      end
      default: st_d = S_IDLE;
    endcase
    if (do_emit) begin
      bw_d = bw_n;
      if (flush && done) fin_d = 1'b1;
    end
  end

  // control and packing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      bw_q      <= '0;
      fin_q     <= 1'b0;
      dist_q    <= 13'd1;
      rem_q     <= 9'd0;
      pk_data_q <= '0;
      pk_cnt_q  <= 4'd0;
      pk_bad_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      bw_q   <= bw_d;
      fin_q  <= fin_d;
      dist_q <= dist_d;
      rem_q  <= rem_d;
      if (do_emit && flush) begin
        pk_data_q <= '0;
        pk_cnt_q  <= 4'd0;
        pk_bad_q  <= 1'b0;
        out_vld_q <= 1'b1;
      end else begin
        if (do_emit) begin
          pk_data_q <= data_n;
          pk_cnt_q  <= cnt_n;
          pk_bad_q  <= pk_bad_q | emit_bad;
        end
        if (!out_stall_i) out_vld_q <= 1'b0;
      end
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (do_emit && flush) begin
      out_q.out_data      <= data_n;
      out_q.out_count     <= cnt_n;
      out_q.run_last      <= over;
      out_q.stream_done   <= done;
      out_q.bad_reference <= pk_bad_q | emit_bad;
    end
  end

  // history window
  always_ff @(posedge clk_i) begin
    if (do_emit) hist[bw_cur[WinAw-1:0]] <= emit_b;
    rd_q <= hist[raddr];
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.out_count != 4'd0) && (out_q.out_count <= 4'(OutBytes)))
    else $error("output byte count out of range");
  a_idle_packer_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> pk_cnt_q == 4'd0) else $error("packer not flushed at command end");
  a_copy_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CRD || st_q == S_CEM) |-> rem_q != 9'd0)
    else $error("copy running with nothing left");
`endif

endmodule
`default_nettype wire

@@ rtl/yaz0_stream_decompressor.sv @@
// top level of the yaz0 stream decompressor
// Yaz0 decompressor taking one compressed byte per input word and returning up to
// OutBytes decompressed bytes per output word. The parser accepts one byte per cycle
// while its two-entry command queue has room; header and code bytes reach the
// executor only as commands that emit nothing. The executor emits a literal as it
// takes the command, and each copied byte passes a read state and then an emit
// state, set by the registered read of the 4096-byte history memory. A full
// output word waits in an output register while the next bytes are being prepared.
// Output of a stream stops at output_length; the user writes the register through
// the configuration channel while the block is idle; the block does not enforce it.
`default_nettype none
module yaz0_stream_decompressor import yaz_pkg::*; #(
  parameter int unsigned OutBytes = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_t             in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_t                 out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [LenW-1:0] cfg_data_i
);

  logic [LenW-1:0] out_len_q;
  logic            push, pop, q_full, q_valid;
  cmd_t            cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  // output length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      out_len_q <= cfg_data_i;
    end
  end

  yaz_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  yaz_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  yaz_back #(
    .OutBytes (OutBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .out_len_i   (out_len_q),
    .q_valid_i   (q_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
